FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/iotok_pkg.sv
// ----------------------------------------------------------------------------
// iotok_pkg
// Types, character codes and token kinds for the integer/operator tokenizer
// ----------------------------------------------------------------------------
package iotok_pkg;

  // field widths
  localparam int KIND_W  = 4;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 24;
  localparam int VAL_W   = 32;
  localparam int DIGIT_W = 8;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_INT       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PLUS      = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MINUS     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_STAR      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SLASH     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ASSIGN    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LESS      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_GREATER   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_LPAREN    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_RPAREN    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_LBRACE    = 4'd10;
  localparam logic [KIND_W-1:0] KIND_RBRACE    = 4'd11;
  localparam logic [KIND_W-1:0] KIND_SEMICOLON = 4'd12;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 4'd13;
  localparam logic [KIND_W-1:0] KIND_END       = 4'd14;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN    = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR      = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMICOLON = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LESS      = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_ASSIGN    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GREATER   = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE    = 8'h7D;

  // input word
  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              end_of_input;
  } src_word_t;

  // result word
  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [CHAR_W-1:0]  token_char;
    logic [POS_W-1:0]   start_line;
    logic [POS_W-1:0]   start_column;
    logic [VAL_W-1:0]   int_value;
    logic [DIGIT_W-1:0] digit_count;
    logic               value_overflow;
    logic               last_result;
  } token_word_t;

  // kind of a single-character token, error for anything else
  function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_PLUS:      k = KIND_PLUS;
      CH_MINUS:     k = KIND_MINUS;
      CH_STAR:      k = KIND_STAR;
      CH_SLASH:     k = KIND_SLASH;
      CH_ASSIGN:    k = KIND_ASSIGN;
      CH_LESS:      k = KIND_LESS;
      CH_GREATER:   k = KIND_GREATER;
      CH_LPAREN:    k = KIND_LPAREN;
      CH_RPAREN:    k = KIND_RPAREN;
      CH_LBRACE:    k = KIND_LBRACE;
      CH_RBRACE:    k = KIND_RBRACE;
      CH_SEMICOLON: k = KIND_SEMICOLON;
      default:      k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/integer_operator_tokenizer_top.sv
// ----------------------------------------------------------------------------
// integer_operator_tokenizer_top
// Byte-stream tokenizer for decimal integers and single-character operators.
// Each accepted word is held in the input stage register; its result words are
// registered in the 3-entry result queue. Throughput: one word per cycle while
// out_stall is low and each word gives at most one token; the input stalls while
// the queue holds more than one word, as after a word that gives two tokens.
// Reset: rst (synchronous) returns line to 1, column to 0 and empties the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_operator_tokenizer_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  iotok_pkg::src_word_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output iotok_pkg::token_word_t out_data
);
  import iotok_pkg::*;

  localparam int QDEPTH = 3;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // input stage
  logic      stage_vld;
  src_word_t stage;

  // tokenizer state
  logic [POS_W-1:0]   line_count,      line_count_next;
  logic [POS_W-1:0]   column_count,    column_count_next;
  logic               cr_pending,      cr_pending_next;
  logic               in_number,       in_number_next;
  logic [VAL_W-1:0]   number_value,    number_value_next;
  logic [DIGIT_W-1:0] number_digits,   number_digits_next;
  logic               number_overflow, number_overflow_next;
  logic [POS_W-1:0]   number_line,     number_line_next;
  logic [POS_W-1:0]   number_column,   number_column_next;

  // result queue
  token_word_t        q [QDEPTH];
  token_word_t        q_next [QDEPTH];
  logic [CNT_W-1:0]   count, count_next, base;

  logic               proc, pop, push0, push1;
  logic               has_a, has_b;
  token_word_t        tok_a, tok_b, word0;

  logic [CHAR_W-1:0]  c;
  logic               digit, is_nl, is_ws;
  logic [3:0]         dval;
  logic [VAL_W+3:0]   acc;

  // saturating position increment
  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    return (p == {POS_W{1'b1}}) ? p : p + 1'b1;
  endfunction

  // handshake control
  assign proc     = stage_vld && (count <= CNT_W'(1));
  assign in_stall = stage_vld && !proc;
  assign pop      = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_data  = q[0];

  // byte classification and digit accumulate
  assign c     = stage.char_in;
  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_nl = (c == CH_CR) || (c == CH_LF);
  assign is_ws = is_nl || (c == CH_SPACE) || (c == CH_TAB);
  assign dval  = 4'(c - CH_ZERO);
  assign acc   = ({4'b0, number_value} << 3) + ({4'b0, number_value} << 1)
               + (VAL_W+4)'(dval);

  // next state and result words for the staged byte
  always_comb begin
    line_count_next      = line_count;
    column_count_next    = column_count;
    cr_pending_next      = cr_pending;
    in_number_next       = in_number;
    number_value_next    = number_value;
    number_digits_next   = number_digits;
    number_overflow_next = number_overflow;
    number_line_next     = number_line;
    number_column_next   = number_column;
    has_a = 1'b0;
    has_b = 1'b0;

    tok_a.token_kind     = KIND_INT;
    tok_a.token_char     = '0;
    tok_a.start_line     = number_line;
    tok_a.start_column   = number_column;
    tok_a.int_value      = number_value;
    tok_a.digit_count    = number_digits;
    tok_a.value_overflow = number_overflow;
    tok_a.last_result    = 1'b0;

    tok_b.token_kind     = KIND_END;
    tok_b.token_char     = '0;
    tok_b.start_line     = line_count;
    tok_b.start_column   = column_count;
    tok_b.int_value      = '0;
    tok_b.digit_count    = '0;
    tok_b.value_overflow = 1'b0;
    tok_b.last_result    = 1'b1;

    if (stage.end_of_input) begin
      // pending number, end token, then back to the reset state
      has_a = in_number;
      has_b = 1'b1;
      line_count_next      = POS_W'(1);
      column_count_next    = '0;
      cr_pending_next      = 1'b0;
      in_number_next       = 1'b0;
      number_value_next    = '0;
      number_digits_next   = '0;
      number_overflow_next = 1'b0;
      number_line_next     = POS_W'(1);
      number_column_next   = '0;
    end else if (cr_pending && (c == CH_LF)) begin
      // lf after cr is swallowed
      cr_pending_next = 1'b0;
    end else begin
      cr_pending_next = 1'b0;
      if (in_number && digit) begin
        // extend the number, saturating on overflow
        if (number_overflow || (acc[VAL_W+3:VAL_W] != '0)) begin
          number_value_next    = {VAL_W{1'b1}};
          number_overflow_next = 1'b1;
        end else begin
          number_value_next = acc[VAL_W-1:0];
        end
        if (number_digits != {DIGIT_W{1'b1}})
          number_digits_next = number_digits + 1'b1;
        column_count_next = pos_inc(column_count);
      end else begin
        has_a          = in_number;
        in_number_next = 1'b0;
        if (is_nl) begin
          line_count_next   = pos_inc(line_count);
          column_count_next = '0;
          cr_pending_next   = (c == CH_CR);
        end else begin
          column_count_next = pos_inc(column_count);
        end
        if (is_ws) begin
          has_b = 1'b0;
        end else if (digit) begin
          in_number_next       = 1'b1;
          number_value_next    = VAL_W'(dval);
          number_digits_next   = DIGIT_W'(1);
          number_overflow_next = 1'b0;
          number_line_next     = line_count;
          number_column_next   = column_count;
        end else begin
          has_b = 1'b1;
          tok_b.token_kind = single_kind(c);
          tok_b.token_char = c;
        end
      end
    end
    tok_a.last_result = !has_b;
  end

  // result queue update
  assign push0 = proc && (has_a || has_b);
  assign push1 = proc && has_a && has_b;
  assign word0 = has_a ? tok_a : tok_b;
  assign base  = count - CNT_W'(pop);
  assign count_next = base + CNT_W'(push0) + CNT_W'(push1);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1))
        q_next[i] = q[i+1];
      else
        q_next[i] = q[i];
      if (push0 && (base == CNT_W'(i)))
        q_next[i] = word0;
      if (push1 && (base + 1'b1 == CNT_W'(i)))
        q_next[i] = tok_b;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld       <= 1'b0;
      count           <= '0;
      line_count      <= POS_W'(1);
      column_count    <= '0;
      cr_pending      <= 1'b0;
      in_number       <= 1'b0;
      number_value    <= '0;
      number_digits   <= '0;
      number_overflow <= 1'b0;
      number_line     <= POS_W'(1);
      number_column   <= '0;
    end else begin
      stage_vld <= (in_valid && !in_stall) || (stage_vld && !proc);
      count     <= count_next;
      if (proc) begin
        line_count      <= line_count_next;
        column_count    <= column_count_next;
        cr_pending      <= cr_pending_next;
        in_number       <= in_number_next;
        number_value    <= number_value_next;
        number_digits   <= number_digits_next;
        number_overflow <= number_overflow_next;
        number_line     <= number_line_next;
        number_column   <= number_column_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      stage <= in_data;
    for (int i = 0; i < QDEPTH; i++)
      q[i] <= q_next[i];
  end

  // checks
  `ASSERT_IMPL(a_count_range, 1'b1, count <= CNT_W'(QDEPTH))
  `ASSERT_IMPL(a_line_nonzero, 1'b1, line_count != '0)
  `ASSERT_IMPL(a_number_digits, in_number, number_digits != '0)
  `ASSERT_NEXT(a_stage_hold, stage_vld && !proc, stage_vld && $stable(stage))

endmodule
